/* rtl/core/gf2rca_pkg.sv */
// ----------------------------------------------------------------------------
// gf2rca_pkg
// Shared constants, types and helpers of the GF(2) convolution accumulator.
// ----------------------------------------------------------------------------
package gf2rca_pkg;

  localparam int VALUE_W       = 64;
  localparam int RAND_W        = 32;
  localparam int ACC_BYTES_W   = 3;
  localparam int BITS_PER_BYTE = 8;
  localparam int ELEM_W        = 64;
  localparam int MAX_ACC_BYTES = 4;
  localparam int WIN_DEPTH     = BITS_PER_BYTE * MAX_ACC_BYTES + 1;
  localparam int WIN_IDX_W     = $clog2(WIN_DEPTH);

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_ACC_BYTES = REG_IDX_W'(0);

  typedef logic [ELEM_W-1:0]      elem_t;
  typedef logic [ACC_BYTES_W-1:0] acc_bytes_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RAND_W-1:0]  rand_bits;
    logic               last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  // clamp the configured byte count to what the window can hold
  function automatic acc_bytes_t sat_bytes(input acc_bytes_t raw);
    acc_bytes_t res;
    if (raw > acc_bytes_t'(MAX_ACC_BYTES)) begin
      res = acc_bytes_t'(MAX_ACC_BYTES);
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

/* rtl/core/gf2rca_stream_if.sv */
// ----------------------------------------------------------------------------
// gf2rca stream interfaces
// Valid/ready channels for input elements and coded results.
// ----------------------------------------------------------------------------
interface gf2rca_in_if;
  import gf2rca_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [RAND_W-1:0]  rand_bits;
  logic               last;

  modport source (output valid, output value, output rand_bits, output last, input ready);
  modport sink   (input valid, input value, input rand_bits, input last, output ready);
endinterface

interface gf2rca_out_if;
  import gf2rca_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] coded;
  logic               last_out;

  modport source (output valid, output coded, output last_out, input ready);
  modport sink   (input valid, input coded, input last_out, output ready);
endinterface

/* rtl/core/gf2rca_cfg.sv */
// ----------------------------------------------------------------------------
// gf2rca_cfg
// APB register file holding the per-element random byte count.
// ----------------------------------------------------------------------------
module gf2rca_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gf2rca_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [gf2rca_pkg::APB_DATA_W-1:0] pwdata,
  output logic [gf2rca_pkg::APB_DATA_W-1:0] prdata,
  output logic                              pready,
  output gf2rca_pkg::acc_bytes_t            acc_bytes
);
  import gf2rca_pkg::*;

  acc_bytes_t acc_bytes_r;
  acc_bytes_t acc_bytes_nxt;
  logic       sel_acc;
  logic       wr_en;

  assign pready  = 1'b1;
  assign sel_acc = (paddr[APB_ADDR_W-1:2] == REG_ACC_BYTES);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    acc_bytes_nxt = acc_bytes_r;
    if (wr_en && sel_acc) begin
      acc_bytes_nxt = pwdata[ACC_BYTES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_bytes_r <= '0;
    end else begin
      acc_bytes_r <= acc_bytes_nxt;
    end
  end

  assign prdata    = sel_acc ? APB_DATA_W'(acc_bytes_r) : '0;
  assign acc_bytes = acc_bytes_r;

endmodule

/* rtl/core/gf2rca_in_stage.sv */
// ----------------------------------------------------------------------------
// gf2rca_in_stage
// Input register; refills in the same cycle the held element is consumed.
// ----------------------------------------------------------------------------
module gf2rca_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  gf2rca_in_if.sink          in_ch,
  input  logic               take,
  output gf2rca_pkg::stage_t stage
);
  import gf2rca_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  accept;

  assign in_ch.ready = !valid_r || take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.value     <= in_ch.value;
      item_r.rand_bits <= in_ch.rand_bits;
      item_r.last      <= in_ch.last;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

/* rtl/core/gf2rca_window.sv */
// ----------------------------------------------------------------------------
// gf2rca_window
// Pending-contribution window: finishes an element and spreads it forward.
// ----------------------------------------------------------------------------
module gf2rca_window (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  gf2rca_pkg::item_t      item,
  input  gf2rca_pkg::acc_bytes_t acc_bytes,
  output gf2rca_pkg::elem_t      fin
);
  import gf2rca_pkg::*;

  elem_t                win_r   [WIN_DEPTH];
  elem_t                win_nxt [WIN_DEPTH];
  acc_bytes_t           nbytes;
  logic [WIN_IDX_W-1:0] final_slot;
  logic                 spread_en;

  assign nbytes     = sat_bytes(acc_bytes);
  assign final_slot = WIN_IDX_W'(nbytes) << $clog2(BITS_PER_BYTE);
  assign spread_en  = (nbytes != '0);
  assign fin        = item.value[ELEM_W-1:0] ^ win_r[0];

  for (genvar s = 0; s < WIN_DEPTH; s++) begin : g_slot
    logic  hit;
    elem_t shifted;

    if (s < WIN_DEPTH - 1) begin : g_rand
      localparam int K    = s / BITS_PER_BYTE;
      localparam int B    = s % BITS_PER_BYTE;
      localparam int RBIT = BITS_PER_BYTE * K + (BITS_PER_BYTE - 1 - B);
      assign shifted = win_r[s+1];
      // random tap inside the active bytes, or the fixed tail tap
      assign hit = spread_en &&
                   (((WIN_IDX_W'(s) < final_slot) && item.rand_bits[RBIT]) ||
                    (WIN_IDX_W'(s) == final_slot));
    end else begin : g_tail
      assign shifted = '0;
      assign hit     = spread_en && (WIN_IDX_W'(s) == final_slot);
    end

    always_comb begin
      if (item.last) begin
        win_nxt[s] = '0;
      end else if (hit) begin
        win_nxt[s] = shifted ^ fin;
      end else begin
        win_nxt[s] = shifted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= '0;
      end
    end else if (fire) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

endmodule

/* rtl/core/gf2rca_out_stage.sv */
// ----------------------------------------------------------------------------
// gf2rca_out_stage
// Result register driving the coded output channel.
// ----------------------------------------------------------------------------
module gf2rca_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  gf2rca_pkg::elem_t fin,
  input  logic              last,
  output logic              out_free,
  gf2rca_out_if.source      out_ch
);
  import gf2rca_pkg::*;

  logic               valid_r;
  logic               valid_nxt;
  logic [VALUE_W-1:0] coded_r;
  logic               last_r;

  assign out_free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      coded_r <= VALUE_W'(fin);
      last_r  <= last;
    end
  end

  assign out_ch.valid    = valid_r;
  assign out_ch.coded    = coded_r;
  assign out_ch.last_out = last_r;

endmodule

/* rtl/core/gf2_random_convolution_accumulator_unit.sv */
// ----------------------------------------------------------------------------
// gf2_random_convolution_accumulator_unit
// Streaming in-place GF(2) convolution accumulator with APB configuration.
// ----------------------------------------------------------------------------
// Each accepted element is XORed with the contribution pending for it and
// returned as coded; the result is then XORed into the next 8*acc_bytes+1
// window slots chosen by rand_bits (bit 7-b of byte k selects distance
// 8k+b+1) plus the last slot. acc_bytes of 0 passes values through, values
// above 4 act as 4, and the window clears after an element with last set.
// The block takes one element per clock cycle while the output is not
// stalled; an accepted element waits in the input register, and its result
// is registered in the output stage. The window register bank of 33 slots
// is updated at once for each element, which sets that rate. Write
// acc_bytes only while no transaction is in flight.
module gf2_random_convolution_accumulator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  gf2rca_in_if.sink                         in_ch,
  gf2rca_out_if.source                      out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gf2rca_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [gf2rca_pkg::APB_DATA_W-1:0] pwdata,
  output logic [gf2rca_pkg::APB_DATA_W-1:0] prdata,
  output logic                              pready
);
  import gf2rca_pkg::*;

  acc_bytes_t acc_bytes;
  stage_t     stage;
  elem_t      fin;
  logic       out_free;
  logic       fire;

  assign fire = stage.valid && out_free;

  gf2rca_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .acc_bytes (acc_bytes)
  );

  gf2rca_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (fire),
    .stage (stage)
  );

  gf2rca_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (stage.item),
    .acc_bytes (acc_bytes),
    .fin       (fin)
  );

  gf2rca_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire),
    .fin      (fin),
    .last     (stage.item.last),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

/* rtl/core/gf2rca_checker.sv */
// ----------------------------------------------------------------------------
// gf2rca_checker
// Port-level assertions for the accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module gf2rca_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [gf2rca_pkg::VALUE_W-1:0]    out_coded,
  input logic                              out_last,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [gf2rca_pkg::APB_ADDR_W-1:0] paddr,
  input logic [gf2rca_pkg::APB_DATA_W-1:0] pwdata,
  input logic [gf2rca_pkg::APB_DATA_W-1:0] prdata
);
  import gf2rca_pkg::*;

  // empty pipeline right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("pipeline not empty after reset");

  // input only backs up when the result side is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while result side is free");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_coded) && $stable(out_last)))
    else $error("stalled result changed");

  // written byte count reads back
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_ACC_BYTES)) |=>
      ((paddr[APB_ADDR_W-1:2] != REG_ACC_BYTES) ||
       (prdata == APB_DATA_W'($past(pwdata[ACC_BYTES_W-1:0])))))
    else $error("acc_bytes readback mismatch");

endmodule

bind gf2_random_convolution_accumulator_unit gf2rca_checker u_gf2rca_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_coded (out_ch.coded),
  .out_last  (out_ch.last_out),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
